// ===== sv/id_slot_table_oldest_replace_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the identifier slot table
// Concurrent checks clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ID_SLOT_TABLE_OLDEST_REPLACE_MACROS_SVH
`define ID_SLOT_TABLE_OLDEST_REPLACE_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold in the same cycle as its antecedent
`define ISTOR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// property that must hold in the cycle after its antecedent
`define ISTOR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ISTOR_ASSERT_NOW(lbl, ante, cons, msg)
`define ISTOR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/istor_pkg.sv =====
// ----------------------------------------------------------------------------
// istor_pkg
// Shared types and constants of the identifier slot table.
// ----------------------------------------------------------------------------
package istor_pkg;

  localparam int SlotsDef = 20;
  localparam int IdW      = 32;
  localparam int TimeW    = 31;
  localparam int SlotW    = 5;
  localparam int OutcomeW = 2;

  typedef enum logic [OutcomeW-1:0] {
    OUT_MATCH  = 2'd0,
    OUT_EMPTY  = 2'd1,
    OUT_OLDEST = 2'd2
  } outcome_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE,
    ST_HOLD
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic start;   // capture request, clear trackers
    logic scan;    // read one slot, advance address
    logic write;   // write back chosen slot
    logic load;    // load result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
  } sts_t;

endpackage

// ===== sv/istor_ctrl.sv =====
// ----------------------------------------------------------------------------
// istor_ctrl
// Sequencer: scan, drain, write-back and result hand-off.
// ----------------------------------------------------------------------------
module istor_ctrl import istor_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last slot read is evaluated here
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        if (out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/istor_dp.sv =====
// ----------------------------------------------------------------------------
// istor_dp
// Slot memories, scan trackers, slot choice and result register.
// ----------------------------------------------------------------------------
module istor_dp import istor_pkg::*; #(
  parameter int SLOTS = SlotsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [IdW-1:0]     ident_i,
  input  logic [TimeW-1:0]   now_seconds_i,
  output logic [SlotW-1:0]   slot_o,
  output logic [OutcomeW-1:0] outcome_o
);

  localparam int IdxW = $clog2(SLOTS);

  logic [IdW-1:0]   ids_mem   [SLOTS];
  logic [TimeW-1:0] times_mem [SLOTS];
  logic [SLOTS-1:0] valid_q;

  logic [IdW-1:0]   ident_q;
  logic [TimeW-1:0] now_q;
  logic [IdxW-1:0]  addr_q;

  logic [IdW-1:0]   rd_id_q;
  logic [TimeW-1:0] rd_time_q;
  logic             rd_vld_q;
  logic             eval_en_q;
  logic [IdxW-1:0]  eval_idx_q;

  logic             match_found_q, empty_found_q;
  logic [IdxW-1:0]  match_idx_q, empty_idx_q, pick_q;
  logic [TimeW-1:0] least_q;

  logic [IdW-1:0]   eff_id;
  logic [TimeW-1:0] eff_time;
  logic [IdxW-1:0]  sel_idx;
  outcome_e         sel_outcome;

  logic [SlotW-1:0]    slot_q;
  logic [OutcomeW-1:0] outcome_q;

  assign sts_o.scan_last = (addr_q == IdxW'(SLOTS - 1));

  // table memories, one read or one write a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      ids_mem[sel_idx]   <= ident_q;
      times_mem[sel_idx] <= now_q;
    end
    if (cmd_i.scan) begin
      rd_id_q   <= ids_mem[addr_q];
      rd_time_q <= times_mem[addr_q];
    end
  end

  // entries never written read as empty, time zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rd_vld_q  <= 1'b0;
      eval_en_q <= 1'b0;
    end else begin
      if (cmd_i.write) begin
        valid_q[sel_idx] <= 1'b1;
      end
      if (cmd_i.scan) begin
        rd_vld_q <= valid_q[addr_q];
      end
      eval_en_q <= cmd_i.scan;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      ident_q <= ident_i;
      now_q   <= now_seconds_i;
      addr_q  <= '0;
    end else if (cmd_i.scan) begin
      addr_q <= addr_q + IdxW'(1);
    end
    if (cmd_i.scan) begin
      eval_idx_q <= addr_q;
    end
  end

  assign eff_id   = rd_vld_q ? rd_id_q : '0;
  assign eff_time = rd_vld_q ? rd_time_q : '0;

  // all three passes tracked in one sweep; lowest slot wins each
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      match_found_q <= 1'b0;
      empty_found_q <= 1'b0;
      match_idx_q   <= '0;
      empty_idx_q   <= '0;
      pick_q        <= '0;
      least_q       <= '1;
    end else if (eval_en_q) begin
      if (!match_found_q && (eff_id == ident_q)) begin
        match_found_q <= 1'b1;
        match_idx_q   <= eval_idx_q;
      end
      if (!empty_found_q && (eff_id == '0)) begin
        empty_found_q <= 1'b1;
        empty_idx_q   <= eval_idx_q;
      end
      if (eff_time < least_q) begin
        least_q <= eff_time;
        pick_q  <= eval_idx_q;
      end
    end
  end

  always_comb begin
    if (match_found_q) begin
      sel_idx     = match_idx_q;
      sel_outcome = OUT_MATCH;
    end else if (empty_found_q) begin
      sel_idx     = empty_idx_q;
      sel_outcome = OUT_EMPTY;
    end else begin
      sel_idx     = pick_q;
      sel_outcome = OUT_OLDEST;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      slot_q    <= SlotW'(sel_idx);
      outcome_q <= sel_outcome;
    end
  end

  assign slot_o    = slot_q;
  assign outcome_o = outcome_q;

endmodule

// ===== sv/id_slot_table_oldest_replace.sv =====
// Identifier slot table: each request carries an identifier and the time in seconds and is
// recorded in the lowest slot holding the same identifier, else the lowest empty slot, else
// the lowest slot with the smallest timestamp (slot 0 if every timestamp is at its maximum).
// The result gives the slot written and how it was chosen. One slot is read per cycle from
// the table memory, then a drain state evaluates the last read and a write state writes the
// slot back. The result waits in an output register, so the next request is taken while it
// is still pending. Reset empties the table at once through per-slot valid bits.
// ----------------------------------------------------------------------------
// id_slot_table_oldest_replace
// Top level: sequencer plus slot table datapath.
// ----------------------------------------------------------------------------
`include "id_slot_table_oldest_replace_macros.svh"

module id_slot_table_oldest_replace import istor_pkg::*; #(
  parameter int SLOTS = SlotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [IdW-1:0]      ident_i,
  input  logic [TimeW-1:0]    now_seconds_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SlotW-1:0]    slot_o,
  output logic [OutcomeW-1:0] outcome_o
);

  cmd_t cmd;
  sts_t sts;

  istor_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  istor_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .ident_i       (ident_i),
    .now_seconds_i (now_seconds_i),
    .slot_o        (slot_o),
    .outcome_o     (outcome_o)
  );

  `ISTOR_ASSERT_NEXT(a_start_scans, cmd.start, cmd.scan && in_stall_o, "scan did not follow accept")
  `ISTOR_ASSERT_NOW(a_outcome_code, out_valid_o, outcome_o <= OUT_OLDEST, "bad outcome code")
  `ISTOR_ASSERT_NOW(a_slot_range, out_valid_o && (SLOTS <= 32), 32'(slot_o) < SLOTS, "slot out of range")
  `ISTOR_ASSERT_NOW(a_load_free, cmd.load && out_valid_o, !out_stall_i, "result overwritten")

endmodule

// ===== tb/id_slot_table_oldest_replace_checker.sv =====
// ----------------------------------------------------------------------------
// id_slot_table_oldest_replace_checker
// Watches both channels, keeps its own copy of the slot table and compares
// every result with the slot and outcome predicted for the oldest request.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module id_slot_table_oldest_replace_checker import istor_pkg::*; #(
  parameter int SLOTS = SlotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_o,
  input  logic [IdW-1:0]      ident_i,
  input  logic [TimeW-1:0]    now_seconds_i,
  input  logic                out_valid_o,
  input  logic                out_stall_i,
  input  logic [SlotW-1:0]    slot_o,
  input  logic [OutcomeW-1:0] outcome_o,
  output int                  fails_o,
  output int                  pending_o
);

  localparam logic [TimeW-1:0] TimeLimit = '1;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    outcome_e         outcome;
  } slot_pick_t;

  logic [IdW-1:0]   tbl_ids   [SLOTS];
  logic [TimeW-1:0] tbl_times [SLOTS];
  slot_pick_t       slot_picks_q [$];
  slot_pick_t       want;
  outcome_e         how;
  int               idx;
  int               fail_cnt = 0;
  int               pending_cnt = 0;

  assign fails_o   = fail_cnt;
  assign pending_o = pending_cnt;

  // match first, then lowest empty, then lowest slot with the smallest time
  function automatic int pick_slot(input logic [IdW-1:0] id, output outcome_e kind);
    int               hit;
    logic [TimeW-1:0] least;
    hit   = -1;
    least = TimeLimit;
    kind  = OUT_OLDEST;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && tbl_ids[i] == id) begin
        hit  = i;
        kind = OUT_MATCH;
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && tbl_ids[i] == '0) begin
        hit  = i;
        kind = OUT_EMPTY;
      end
    end
    if (hit < 0) begin
      // nothing below the limit leaves slot 0
      hit = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (tbl_times[i] < least) begin
          least = tbl_times[i];
          hit   = i;
        end
      end
    end
    return hit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        tbl_ids[i]   = '0;
        tbl_times[i] = '0;
      end
      slot_picks_q.delete();
      pending_cnt = 0;
    end else begin
      // results drain before the new request is predicted
      if (out_valid_o && !out_stall_i) begin
        if (slot_picks_q.size() == 0) begin
          $error("unexpected result: slot %0d, outcome %0d", slot_o, outcome_o);
          fail_cnt++;
        end else begin
          want = slot_picks_q.pop_front();
          if (slot_o !== want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, slot_o);
            fail_cnt++;
          end
          if (outcome_o !== want.outcome) begin
            $error("outcome: expected %0d, actual %0d", want.outcome, outcome_o);
            fail_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        idx            = pick_slot(ident_i, how);
        tbl_ids[idx]   = ident_i;
        tbl_times[idx] = now_seconds_i;
        want.slot      = SlotW'(idx);
        want.outcome   = how;
        slot_picks_q.push_back(want);
      end
      pending_cnt = slot_picks_q.size();
    end
  end

endmodule

// ===== tb/tb_id_slot_table_oldest_replace.sv =====
// ----------------------------------------------------------------------------
// tb_id_slot_table_oldest_replace
// Drives directed and random requests into the slot table with random gaps
// and output stalls; the checker predicts and compares, this gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_id_slot_table_oldest_replace;
  import istor_pkg::*;

  localparam int               PoolSize  = 28;
  localparam int               Watchdog  = 2000;
  localparam logic [TimeW-1:0] TimeMax   = '1;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [IdW-1:0]      ident_i = '0;
  logic [TimeW-1:0]    now_seconds_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [SlotW-1:0]    slot_o;
  logic [OutcomeW-1:0] outcome_o;

  int fails;
  int pending;
  int stall_left = 0;
  int idle_cycles = 0;
  bit tx_gaps = 1'b0;
  bit rx_stalls = 1'b0;

  id_slot_table_oldest_replace #(.SLOTS(SlotsDef)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .ident_i, .now_seconds_i,
    .out_valid_o, .out_stall_i, .slot_o, .outcome_o
  );

  id_slot_table_oldest_replace_checker #(.SLOTS(SlotsDef)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .ident_i, .now_seconds_i,
    .out_valid_o, .out_stall_i, .slot_o, .outcome_o,
    .fails_o(fails), .pending_o(pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk_i) begin
    if (!rx_stalls) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left  <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= Watchdog) begin
      $display("tb_id_slot_table_oldest_replace: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input logic [IdW-1:0] id, input logic [TimeW-1:0] t);
    int gap;
    in_valid_i    <= 1'b1;
    ident_i       <= id;
    now_seconds_i <= t;
    do @(posedge clk_i); while (in_stall_o);
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    logic [IdW-1:0]   pool [PoolSize];
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] t;
    logic [TimeW-1:0] wall;
    logic [31:0]      raw;
    int               time_mode;
    int               r;

    for (int i = 0; i < PoolSize; i++) begin
      pool[i] = $urandom();
      if (pool[i] == '0) pool[i] = 32'h1;
    end
    raw  = $urandom();
    wall = {1'b0, raw[29:0]};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero id hits the lowest empty slot as a match
    send_request('0, '0);
    send_request('1, TimeMax);
    for (int i = 1; i < SlotsDef; i++) send_request(32'hA5A5_0000 | i, TimeMax);
    // table full, every time at the limit: slot 0 goes
    send_request(32'h8000_0001, 31'd100);
    send_request(32'hA5A5_0007, 31'd100);
    // slots 0 and 7 tie on the oldest time, lowest wins
    send_request(32'h7FFF_FFFE, 31'd5);
    // zero id with no empty slot replaces the oldest
    send_request('0, 31'd200);

    for (int blk = 0; blk < 11; blk++) begin
      tx_gaps   = (blk % 4) != 1;
      rx_stalls <= (blk % 4) != 2;
      time_mode = (blk == 5) ? 2 : ((blk == 2 || blk == 8) ? 1 : 0);
      for (int n = 0; n < 100; n++) begin
        r = $urandom_range(0, 99);
        if (r < 4) id = '0;
        else if (r < 22) id = $urandom();
        else id = pool[$urandom_range(0, PoolSize - 1)];
        if ($urandom_range(0, 49) == 0) pool[$urandom_range(0, PoolSize - 1)] = $urandom();

        raw = $urandom();
        case (time_mode)
          2: t = TimeMax;
          1: t = ($urandom_range(0, 7) == 0) ? TimeMax : raw[30:0];
          default: begin
            // running clock; small steps give equal timestamps
            if ($urandom_range(0, 19) == 0) wall = wall + raw[19:0];
            else wall = wall + 31'($urandom_range(0, 3));
            if (wall > 31'h7FFF_0000) wall = {11'd0, raw[19:0]};
            t = wall;
          end
        endcase
        send_request(id, t);
      end
    end
    in_valid_i <= 1'b0;
    rx_stalls  <= 1'b0;

    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4 * SlotsDef) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("tb_id_slot_table_oldest_replace: PASS");
    end else begin
      $display("tb_id_slot_table_oldest_replace: FAIL");
    end
    $finish;
  end

endmodule
